@@ rtl/pc_sample_histogram_top_defines.svh @@
// Assertion macros for pc_sample_histogram_top.sv, which checks its own logic with them.
`ifndef PC_SAMPLE_HISTOGRAM_TOP_DEFINES_SVH
`define PC_SAMPLE_HISTOGRAM_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define PHS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define PHS_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define PHS_ASSERT(lbl, prop, msg)
`define PHS_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

@@ rtl/phs_pkg.sv @@
package phs_pkg;

	localparam int PC_W       = 32;
	localparam int TICKS_W    = 16;
	localparam int SCALE_W    = 17;
	localparam int BBYTES_W   = 14;
	localparam int FRAC_W     = 16;
	localparam int PROD_W     = PC_W + SCALE_W;
	localparam int BIN_OUT_W  = 12;
	localparam int COUNT_W    = 16;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 32;

	localparam int BINS_DEFAULT    = 4096;
	localparam int PC_BITS_DEFAULT = 32;
	localparam int QUEUE_DEPTH     = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ENABLE       = 8'd0,
		REG_PC_OFFSET    = 8'd1,
		REG_SCALE        = 8'd2,
		REG_BUFFER_BYTES = 8'd3
	} phs_reg_t;

	typedef struct packed {
		logic                enable;
		logic [PC_W-1:0]     pc_offset;
		logic [SCALE_W-1:0]  scale;
		logic [BBYTES_W-1:0] buffer_bytes;
	} phs_cfg_t;

	typedef enum logic [1:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_ADD,
		BK_SEND
	} phs_back_state_t;

endpackage

@@ rtl/phs_in_if.sv @@
interface phs_in_if;
	import phs_pkg::*;

	logic               valid;
	logic               ready;
	logic [PC_W-1:0]    pc;
	logic [TICKS_W-1:0] ticks;

	modport source (output valid, pc, ticks, input ready);
	modport sink (input valid, pc, ticks, output ready);
endinterface

@@ rtl/phs_out_if.sv @@
interface phs_out_if;
	import phs_pkg::*;

	logic                 valid;
	logic                 ready;
	logic                 counted;
	logic [BIN_OUT_W-1:0] bin;
	logic [COUNT_W-1:0]   count;

	modport source (output valid, counted, bin, count, input ready);
	modport sink (input valid, counted, bin, count, output ready);
endinterface

@@ rtl/phs_fifo.sv @@
module phs_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             nonempty
);
	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] entries_q [DEPTH];
	logic [PtrW-1:0]  wr_ptr_q;
	logic [PtrW-1:0]  rd_ptr_q;
	logic [CntW-1:0]  fill_q;
	logic             wr;
	logic             rd;

	assign full     = (fill_q == CntW'(DEPTH));
	assign nonempty = (fill_q != '0);
	assign wr       = push && !full;
	assign rd       = pop && nonempty;
	assign pop_data = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr && !rd) begin
				fill_q <= fill_q + 1'b1;
			end else if (rd && !wr) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end
endmodule

@@ rtl/phs_front.sv @@
module phs_front #(
	parameter int BINS    = phs_pkg::BINS_DEFAULT,
	parameter int PC_BITS = phs_pkg::PC_BITS_DEFAULT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  phs_pkg::phs_cfg_t   cfg,
	input  logic                hold_off,
	phs_in_if.sink              sample,
	output logic                push,
	output logic [$clog2(BINS)+phs_pkg::TICKS_W:0] push_data,
	input  logic                full
);
	import phs_pkg::*;

	localparam int IdxW = $clog2(BINS);
	localparam int PcW  = (PC_BITS < PC_W) ? PC_BITS : PC_W;
	localparam logic [PC_W-1:0] PcMask = {PC_W{1'b1}} >> (PC_W - PcW);
	localparam int OffW = PROD_W - FRAC_W - 1;

	logic                stall;
	logic                take;
	logic [PC_W-1:0]     pc_m;
	logic [PC_W-1:0]     base_m;
	logic [OffW-1:0]     off_half;
	logic                in_buf;
	logic                in_bins;

	logic                v_s1, v_s2, v_s3;
	logic                drop_s1, drop_s2;
	logic [PC_W-1:0]     dist_s1;
	logic [TICKS_W-1:0]  ticks_s1, ticks_s2, ticks_s3;
	logic [PROD_W-1:0]   prod_s2;
	logic                counted_s3;
	logic [IdxW-1:0]     idx_s3;

	// The whole pipe freezes while the last stage waits on a full queue.
	assign stall        = v_s3 && full;
	assign sample.ready = !stall && !hold_off;
	assign take         = sample.valid && sample.ready;

	assign pc_m   = sample.pc & PcMask;
	assign base_m = cfg.pc_offset & PcMask;

	// Half the byte offset is the bin index; the byte offset has bit zero clear.
	assign off_half = prod_s2[PROD_W-1:FRAC_W+1];
	assign in_buf   = {off_half, 1'b0} < (OffW + 1)'(cfg.buffer_bytes);
	assign in_bins  = {1'b0, off_half} < (OffW + 1)'(BINS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (!stall) begin
			v_s1 <= take;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall) begin
			drop_s1    <= !cfg.enable || (sample.ticks == '0) || (pc_m < base_m);
			dist_s1    <= pc_m - base_m;
			ticks_s1   <= sample.ticks;
			prod_s2    <= PROD_W'(dist_s1) * PROD_W'(cfg.scale);
			drop_s2    <= drop_s1;
			ticks_s2   <= ticks_s1;
			counted_s3 <= !drop_s2 && in_buf && in_bins;
			idx_s3     <= off_half[IdxW-1:0];
			ticks_s3   <= ticks_s2;
		end
	end

	assign push      = v_s3;
	assign push_data = {counted_s3, idx_s3, ticks_s3};
endmodule

@@ rtl/phs_back.sv @@
module phs_back #(
	parameter int BINS = phs_pkg::BINS_DEFAULT
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  nonempty,
	input  logic [$clog2(BINS)+phs_pkg::TICKS_W:0] pop_data,
	output logic  pop,
	output logic  clearing,
	phs_out_if.source result
);
	import phs_pkg::*;

	localparam int IdxW = $clog2(BINS);
	localparam int EntW = 1 + IdxW + TICKS_W;

	phs_back_state_t     state_q, state_d;
	logic [COUNT_W-1:0]  bins_q [BINS];
	logic [COUNT_W-1:0]  rdata_q;
	logic [IdxW-1:0]     clr_q;
	logic                counted_q;
	logic [IdxW-1:0]     idx_q;
	logic [TICKS_W-1:0]  ticks_q;
	logic [COUNT_W-1:0]  sum_q;
	logic                res_valid_q;
	logic                res_counted_q;
	logic [BIN_OUT_W-1:0] res_bin_q;
	logic [COUNT_W-1:0]  res_count_q;

	logic                ent_counted;
	logic [IdxW-1:0]     ent_idx;
	logic [TICKS_W-1:0]  ent_ticks;
	logic                slot_free;
	logic                load_ent;
	logic                load_res;
	logic                mem_we;
	logic [IdxW-1:0]     mem_waddr;
	logic [COUNT_W-1:0]  mem_wdata;

	assign ent_counted = pop_data[EntW-1];
	assign ent_idx     = pop_data[TICKS_W +: IdxW];
	assign ent_ticks   = pop_data[TICKS_W-1:0];
	assign slot_free   = !res_valid_q || result.ready;
	assign clearing    = (state_q == BK_CLEAR);

	always_comb begin
		state_d   = state_q;
		pop       = 1'b0;
		load_ent  = 1'b0;
		load_res  = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = clr_q;
		mem_wdata = '0;
		unique case (state_q)
			BK_CLEAR: begin
				mem_we = 1'b1;
				if (clr_q == IdxW'(BINS - 1)) begin
					state_d = BK_IDLE;
				end
			end
			BK_IDLE: begin
				if (nonempty) begin
					pop      = 1'b1;
					load_ent = 1'b1;
					state_d  = ent_counted ? BK_ADD : BK_SEND;
				end
			end
			BK_ADD: begin
				mem_we    = 1'b1;
				mem_waddr = idx_q;
				mem_wdata = rdata_q + ticks_q;
				state_d   = BK_SEND;
			end
			BK_SEND: begin
				if (slot_free) begin
					load_res = 1'b1;
					state_d  = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_CLEAR;
			clr_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == BK_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (load_res) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_ent) begin
			counted_q <= ent_counted;
			idx_q     <= ent_idx;
			ticks_q   <= ent_ticks;
			sum_q     <= '0;
		end else if (state_q == BK_ADD) begin
			sum_q <= mem_wdata;
		end
		if (load_res) begin
			res_counted_q <= counted_q;
			res_bin_q     <= counted_q ? BIN_OUT_W'(idx_q) : '0;
			res_count_q   <= sum_q;
		end
	end

	// Bin store with one write port and one read port: the read issued at pop is ready for the add.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			bins_q[mem_waddr] <= mem_wdata;
		end
		rdata_q <= bins_q[ent_idx];
	end

	assign result.valid   = res_valid_q;
	assign result.counted = res_counted_q;
	assign result.bin     = res_bin_q;
	assign result.count   = res_count_q;
endmodule

@@ rtl/pc_sample_histogram_top.sv @@
// Program counter sampling histogram. Each accepted sample (pc, ticks) yields exactly one
// result transaction, in order: counted with the bin index and the bin's new 16-bit value,
// or all zero when the sample is dropped. A sample passes a three-stage classify pipeline
// (range check, 32x17 scale multiply, buffer and bin limit compare), waits in a two-entry
// queue, and is then applied by a read, add and write sequence on the bin memory. The back end
// takes one sample at a time and pops the next from the queue only after it has applied the
// last one (a read, add and write on the single write port of the bin memory, for a counted
// sample) and handed its result on. After reset the block clears the bin memory, one bin per
// cycle; sample.ready stays low during that pass, while configuration writes are taken at any
// time.
`include "pc_sample_histogram_top_defines.svh"

module pc_sample_histogram_top #(
	parameter int BINS    = phs_pkg::BINS_DEFAULT,
	parameter int PC_BITS = phs_pkg::PC_BITS_DEFAULT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [phs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [phs_pkg::CFG_DATA_W-1:0] cfg_wdata,
	phs_in_if.sink                         sample,
	phs_out_if.source                      result
);
	import phs_pkg::*;

	localparam int IdxW = $clog2(BINS);
	localparam int EntW = 1 + IdxW + TICKS_W;

	phs_cfg_t          cfg_q;
	logic              clearing;
	logic              q_push;
	logic [EntW-1:0]   q_push_data;
	logic              q_full;
	logic              q_pop;
	logic [EntW-1:0]   q_pop_data;
	logic              q_nonempty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ENABLE:       cfg_q.enable       <= cfg_wdata[0];
				REG_PC_OFFSET:    cfg_q.pc_offset    <= cfg_wdata[PC_W-1:0];
				REG_SCALE:        cfg_q.scale        <= cfg_wdata[SCALE_W-1:0];
				REG_BUFFER_BYTES: cfg_q.buffer_bytes <= cfg_wdata[BBYTES_W-1:0];
				default: ;
			endcase
		end
	end

	phs_front #(
		.BINS    (BINS),
		.PC_BITS (PC_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.hold_off  (clearing),
		.sample    (sample),
		.push      (q_push),
		.push_data (q_push_data),
		.full      (q_full)
	);

	phs_fifo #(
		.WIDTH (EntW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_push_data),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_pop_data),
		.nonempty  (q_nonempty)
	);

	phs_back #(
		.BINS (BINS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.nonempty (q_nonempty),
		.pop_data (q_pop_data),
		.pop      (q_pop),
		.clearing (clearing),
		.result   (result)
	);

	`PHS_ASSERT(a_drop_is_zero, (result.valid && !result.counted) |-> (result.bin == '0 && result.count == '0), "dropped result carries a nonzero bin or count")
	`PHS_ASSERT_NEVER(a_no_result_while_clearing, clearing && result.valid, "result offered during the clearing pass")
	`PHS_ASSERT_NEVER(a_no_queue_work_while_clearing, clearing && q_nonempty, "queue holds a sample during the clearing pass")
endmodule

@@ dv/pc_sample_histogram_top_tb.sv @@
`timescale 1ns / 1ps

module pc_sample_histogram_top_tb;
	import phs_pkg::*;

	localparam int HIST_BINS   = BINS_DEFAULT;
	localparam int SETTLE      = 12;
	localparam int HOLD_CYCLES = 80;
	localparam int CYCLE_LIMIT = 200000;
	localparam int RAND_PHASES = 8;
	localparam int PHASE_ITEMS = 120;

	// An index that maps to no register; writes to it must change nothing.
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 8'hC3;

	typedef struct packed {
		logic                 counted;
		logic [BIN_OUT_W-1:0] bin;
		logic [COUNT_W-1:0]   count;
	} hist_result_t;

	class histogram_scoreboard;
		bit                  prof_on;
		bit [PC_W-1:0]       pc_base;
		bit [SCALE_W-1:0]    scale_q;
		bit [BBYTES_W-1:0]   buf_bytes;
		bit [COUNT_W-1:0]    bin_counts[HIST_BINS];
		hist_result_t        pending[$];
		int                  failures;
		int                  n_samples;
		int                  n_counted;

		function new();
			prof_on = 0;
			pc_base = '0;
			scale_q = '0;
			buf_bytes = '0;
			foreach (bin_counts[i]) bin_counts[i] = '0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_ENABLE:       prof_on = data[0];
				REG_PC_OFFSET:    pc_base = data[PC_W-1:0];
				REG_SCALE:        scale_q = data[SCALE_W-1:0];
				REG_BUFFER_BYTES: buf_bytes = data[BBYTES_W-1:0];
				default: ;
			endcase
		endfunction

		function void note_sample(logic [PC_W-1:0] pc, logic [TICKS_W-1:0] ticks);
			hist_result_t r;
			logic [63:0]  span;
			logic [63:0]  byte_off;
			logic [63:0]  idx;
			r = '0;
			n_samples++;
			if (prof_on && ticks != 0 && pc >= pc_base) begin
				span = 64'(pc - pc_base);
				byte_off = ((span * 64'(scale_q)) >> FRAC_W) & ~64'd1;
				idx = byte_off >> 1;
				if (byte_off < 64'(buf_bytes) && idx < HIST_BINS) begin
					bin_counts[idx] = bin_counts[idx] + ticks;
					r.counted = 1'b1;
					r.bin = idx[BIN_OUT_W-1:0];
					r.count = bin_counts[idx];
					n_counted++;
				end
			end
			pending.push_back(r);
		endfunction

		function void check_result(logic counted, logic [BIN_OUT_W-1:0] bin,
			logic [COUNT_W-1:0] count);
			hist_result_t want;
			if (pending.size() == 0) begin
				$error("result transaction with no sample waiting");
				failures++;
				return;
			end
			want = pending.pop_front();
			if (counted !== want.counted) begin
				$error("counted: expected %0d, got %0d", want.counted, counted);
				failures++;
			end
			if (bin !== want.bin) begin
				$error("bin: expected %0d, got %0d", want.bin, bin);
				failures++;
			end
			if (count !== want.count) begin
				$error("count: expected 0x%04h, got 0x%04h", want.count, count);
				failures++;
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	phs_in_if  sample_ch();
	phs_out_if result_ch();

	histogram_scoreboard board = new();
	bit steady;
	bit hold_requested;
	int settings_used;
	int cycle_count;

	pc_sample_histogram_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.sample    (sample_ch),
		.result    (result_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL pc_sample_histogram_top");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready)
			board.check_result(result_ch.counted, result_ch.bin, result_ch.count);
	end

	// Result side: random back-pressure, plus one long hold-off when asked for.
	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_requested) begin
				hold_requested = 1'b0;
				repeat (HOLD_CYCLES) begin
					result_ch.ready <= 1'b0;
					@(negedge clk);
				end
			end
			result_ch.ready <= (!steady && $urandom_range(99) < 18) ? 1'b0 : 1'b1;
		end
	end

	// Called and returns at a falling edge; valid stays high after acceptance.
	task automatic send_sample(input logic [PC_W-1:0] pc, input logic [TICKS_W-1:0] ticks);
		while (!steady && $urandom_range(99) < 18) begin
			sample_ch.valid <= 1'b0;
			@(negedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.pc <= pc;
		sample_ch.ticks <= ticks;
		do @(posedge clk); while (!(sample_ch.valid && sample_ch.ready));
		board.note_sample(pc, ticks);
		@(negedge clk);
	endtask

	task automatic wait_idle();
		sample_ch.valid <= 1'b0;
		while (board.pending.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	// Leaves cfg_we high; the caller lowers it after its last write.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(negedge clk);
		board.write_reg(idx, data);
	endtask

	task automatic apply_settings(input logic [CFG_DATA_W-1:0] en, input logic [CFG_DATA_W-1:0] base,
		input logic [CFG_DATA_W-1:0] scale, input logic [CFG_DATA_W-1:0] bbytes);
		write_reg(REG_ENABLE, en);
		write_reg(REG_PC_OFFSET, base);
		write_reg(REG_SCALE, scale);
		write_reg(REG_BUFFER_BYTES, bbytes);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	task automatic run_random_phase(input int phase);
		bit                  en;
		logic [PC_W-1:0]     base;
		logic [SCALE_W-1:0]  scale;
		logic [BBYTES_W-1:0] bbytes;
		logic [63:0]         reach;
		logic [PC_W-1:0]     hot_pc;
		logic [PC_W-1:0]     pc;
		logic [TICKS_W-1:0]  ticks;
		int                  pick;
		en = ($urandom_range(9) != 0);
		case ($urandom_range(3))
			0: base = '0;
			1: base = $urandom();
			2: base = $urandom() | 32'hFFFF_0000;
			default: base = $urandom_range(32'hFFFF);
		endcase
		case ($urandom_range(4))
			0: scale = 17'h10000;
			1: scale = SCALE_W'($urandom_range(17'h1FFFF, 1));
			2: scale = SCALE_W'($urandom_range(17'h400, 1));
			3: scale = 17'h1FFFF;
			default: scale = SCALE_W'($urandom_range(17'h10000, 17'h8000));
		endcase
		case ($urandom_range(3))
			0: bbytes = 14'd8192;
			1: bbytes = BBYTES_W'($urandom_range(64, 2));
			2: bbytes = BBYTES_W'($urandom_range(14'h3FFF));
			default: bbytes = 14'h3FFF;
		endcase
		// Unused high bits of the write data carry junk the block must drop.
		apply_settings(($urandom() & ~32'h1) | 32'(en), base,
			($urandom() & ~32'h1FFFF) | 32'(scale),
			($urandom() & ~32'h3FFF) | 32'(bbytes));

		if (scale == 0)
			reach = 64'hFFFF_FFFF;
		else
			reach = ((64'(bbytes) << FRAC_W) / scale) + 4;
		if (reach > 64'hFFFF_FFFF)
			reach = 64'hFFFF_FFFF;
		hot_pc = base;

		steady = (phase == 2);
		for (int n = 0; n < PHASE_ITEMS; n++) begin
			if (phase == 4 && n == 30)
				hold_requested = 1'b1;
			pick = $urandom_range(99);
			if (pick < 60) begin
				pc = base + $urandom_range(reach[31:0], 0);
				hot_pc = pc;
			end else if (pick < 75) begin
				pc = hot_pc;
			end else if (pick < 85) begin
				pc = base - $urandom_range(16, 1);
			end else begin
				pc = $urandom();
			end
			pick = $urandom_range(99);
			if (pick < 40)
				ticks = TICKS_W'($urandom());
			else if (pick < 75)
				ticks = TICKS_W'($urandom_range(8, 1));
			else if (pick < 92)
				ticks = TICKS_W'(32'hFFFF - $urandom_range(3));
			else
				ticks = '0;
			send_sample(pc, ticks);
		end
		wait_idle();
		steady = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		sample_ch.valid = 1'b0;
		sample_ch.pc = '0;
		sample_ch.ticks = '0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Registers still at reset: profiling off, so both are dropped.
		send_sample(32'h0000_1000, 16'd7);
		send_sample(32'hFFFF_FFFF, 16'hFFFF);
		wait_idle();

		// Unit scale: bin edges, wrap of a bin, ticks of zero, pc below the base.
		apply_settings(32'd1, 32'h1000, 32'h10000, 32'd8192);
		send_sample(32'h1000, 16'd1);
		send_sample(32'h1000, 16'hFFFF);
		send_sample(32'h1001, 16'd3);
		send_sample(32'h0FFF, 16'd5);
		send_sample(32'h1000 + 8191, 16'h8000);
		send_sample(32'h1000 + 8192, 16'd9);
		send_sample(32'h1000 + 20, 16'd0);
		send_sample(32'hFFFF_FFFF, 16'hFFFF);
		send_sample(32'h1000 + 100, 16'h1234);
		wait_idle();

		// Scale above one and a buffer larger than the bins cover.
		apply_settings(32'd1, 32'd0, 32'h1FFFF, 32'h3FFF);
		send_sample(32'd4095, 16'd2);
		send_sample(32'd4096, 16'd2);
		send_sample(32'd4097, 16'd2);
		send_sample(32'd0, 16'hFFFF);
		wait_idle();

		// Zero scale maps every covered pc to the first bin.
		apply_settings(32'd1, 32'hFFFF_F000, 32'd0, 32'd1);
		send_sample(32'hFFFF_FFFF, 16'd1);
		send_sample(32'h0000_0000, 16'd1);
		send_sample(32'hFFFF_F000, 16'hFFFF);
		wait_idle();

		write_reg(REG_UNMAPPED, 32'hFFFF_FFFF);
		write_reg(REG_BUFFER_BYTES, 32'd0);
		cfg_we <= 1'b0;
		send_sample(32'hFFFF_F800, 16'd4);
		wait_idle();
		write_reg(REG_ENABLE, 32'd0);
		write_reg(REG_BUFFER_BYTES, 32'd8192);
		cfg_we <= 1'b0;
		send_sample(32'hFFFF_F000, 16'd1);
		wait_idle();

		for (int p = 0; p < RAND_PHASES; p++)
			run_random_phase(p);

		$display("Run covered %0d samples over %0d register settings.",
			board.n_samples, settings_used);
		$display("%0d samples were counted into bins and %0d were dropped.",
			board.n_counted, board.n_samples - board.n_counted);
		if (board.failures == 0)
			$display("PASS pc_sample_histogram_top");
		else
			$display("FAIL pc_sample_histogram_top");
		$finish;
	end

endmodule
